### src/cvr_pkg.sv
// Shared types and constants of the collision velocity response core.
package cvr_pkg;

	localparam int LANES = 6;
	localparam int VEL_W = 32;
	localparam int NUM_W = 64;
	localparam int DEN_W = 30;
	localparam int QUO_W = 34;

	localparam logic [1:0] FIX_NONE = 2'b00;
	localparam logic [1:0] FIX_A    = 2'b01;
	localparam logic [1:0] FIX_B    = 2'b10;
	localparam logic [1:0] FIX_BOTH = 2'b11;

	// One velocity lane on its way through the divider: the dividend magnitude
	// (later the running remainder), the divisor, the quotient sign and the base
	// velocity that the quotient is added to.
	typedef struct packed {
		logic [NUM_W-1:0] mag;
		logic [DEN_W-1:0] den;
		logic             neg;
		logic [VEL_W-1:0] base;
	} lane_t;

	typedef lane_t [LANES-1:0] lane_vec_t;
	typedef logic [LANES-1:0][VEL_W-1:0] tag_t;
	typedef logic [LANES-1:0][QUO_W-1:0] quo_vec_t;

endpackage

### src/cvr_div.sv
// Pipelined restoring divider for six lanes, one quotient bit per stage.
module cvr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cvr_pkg::lane_vec_t in_lane,
	input  cvr_pkg::tag_t     in_tag,
	output logic              out_valid,
	input  logic              out_ready,
	output cvr_pkg::lane_vec_t out_lane,
	output cvr_pkg::quo_vec_t out_quo,
	output cvr_pkg::tag_t     out_tag
);

	localparam int NS = cvr_pkg::QUO_W;

	logic               vld_s  [NS];
	logic               en_s   [NS];
	cvr_pkg::lane_vec_t lane_s [NS];
	cvr_pkg::quo_vec_t  quo_s  [NS];
	cvr_pkg::tag_t      tag_s  [NS];

	for (genvar j = 0; j < NS; j++) begin : g_stage
		localparam int K = NS - 1 - j;

		logic               prev_vld;
		cvr_pkg::lane_vec_t prev_lane;
		cvr_pkg::quo_vec_t  prev_quo;
		cvr_pkg::tag_t      prev_tag;
		cvr_pkg::lane_vec_t nxt_lane;
		cvr_pkg::quo_vec_t  nxt_quo;

		if (j == 0) begin : g_first
			assign prev_vld  = in_valid;
			assign prev_lane = in_lane;
			assign prev_quo  = '0;
			assign prev_tag  = in_tag;
		end else begin : g_next
			assign prev_vld  = vld_s[j-1];
			assign prev_lane = lane_s[j-1];
			assign prev_quo  = quo_s[j-1];
			assign prev_tag  = tag_s[j-1];
		end

		if (j == NS - 1) begin : g_last_en
			assign en_s[j] = !vld_s[j] || out_ready;
		end else begin : g_mid_en
			assign en_s[j] = !vld_s[j] || en_s[j+1];
		end

		// The dividend is known to stay below den * 2^QUO_W, so the top trial
		// shift never drops a set bit.
		always_comb begin
			logic [cvr_pkg::NUM_W-1:0] trial;
			logic                      ge;
			nxt_lane = prev_lane;
			nxt_quo  = prev_quo;
			for (int l = 0; l < cvr_pkg::LANES; l++) begin
				trial = cvr_pkg::NUM_W'(prev_lane[l].den) << K;
				ge    = prev_lane[l].mag >= trial;
				if (ge) begin
					nxt_lane[l].mag = prev_lane[l].mag - trial;
				end
				nxt_quo[l] = {prev_quo[l][cvr_pkg::QUO_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en_s[j]) begin
				vld_s[j] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en_s[j]) begin
				lane_s[j] <= nxt_lane;
				quo_s[j]  <= nxt_quo;
				tag_s[j]  <= prev_tag;
			end
		end
	end

	assign in_ready  = en_s[0];
	assign out_valid = vld_s[NS-1];
	assign out_lane  = lane_s[NS-1];
	assign out_quo   = quo_s[NS-1];
	assign out_tag   = tag_s[NS-1];

endmodule

### src/collision_velocity_response_core.sv
// Top level of the collision velocity response core.
//
// channel | dir | handshake           | contents
// s_*     | in  | s_tvalid / s_tready | one contact pair: velocities, masses, normal, fix mode
// m_*     | out | m_tvalid / m_tready | new velocities and position corrections
//
// One item per cycle sustained while m_tready stays high; the pipeline is five front
// stages, the 34 stage divider at one quotient bit per stage, and the output register.
// Reset clears only the valid bits; payload registers are not reset.
// Every stage holds its item while the next is full, so a stall on m_tready
// fills the bubbles first and only then drops s_tready.
module collision_velocity_response_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z, mass_a, mass_b,
	// normal_x, normal_y, normal_z (32 bits each)
	input  logic [351:0] s_tdata,
	// fix_mode
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// new_vel_a_x, new_vel_a_y, new_vel_a_z, new_vel_b_x, new_vel_b_y, new_vel_b_z,
	// shift_a_x, shift_a_y, shift_a_z, shift_b_x, shift_b_y, shift_b_z (32 bits each)
	output logic [383:0] m_tdata
);

	localparam int R_LIM = 14;
	localparam int M_LIM = 29;
	localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
	localparam int RECIP10_SH = 35;

	function automatic logic [4:0] msb32(input logic [31:0] x);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) p = 5'(i);
		end
		return p;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [35:0] x);
		logic [31:0] r;
		if (x > 36'sd2147483647) r = 32'h7FFFFFFF;
		else if (x < -36'sd2147483648) r = 32'h80000000;
		else r = x[31:0];
		return r;
	endfunction

	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_o;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic div_in_ready, div_out_valid;

	// Stage 1: unpack, reduce the normal and the masses.
	logic signed [31:0] in_va [3];
	logic signed [31:0] in_vb [3];
	logic signed [31:0] in_n  [3];
	logic [31:0]        in_nmag [3];
	logic signed [14:0] in_r [3];
	logic [28:0]        in_ma, in_mb;

	always_comb begin
		logic [31:0] nor_all, mor, ma, mb;
		logic [4:0]  nsh;
		logic [1:0]  msh;
		logic [31:0] rm;
		nor_all = '0;
		for (int i = 0; i < 3; i++) begin
			in_va[i]   = s_tdata[32*i +: 32];
			in_vb[i]   = s_tdata[96 + 32*i +: 32];
			in_n[i]    = s_tdata[256 + 32*i +: 32];
			in_nmag[i] = in_n[i][31] ? 32'(-in_n[i]) : 32'(in_n[i]);
			nor_all    = nor_all | in_nmag[i];
		end
		// Shifting all magnitudes together, the largest one's top bit is the
		// top bit of their OR.
		nsh = (|nor_all[31:R_LIM]) ? msb32(nor_all) - 5'(R_LIM - 1) : 5'd0;
		for (int i = 0; i < 3; i++) begin
			rm      = in_nmag[i] >> nsh;
			in_r[i] = in_n[i][31] ? -$signed({1'b0, rm[13:0]}) : $signed({1'b0, rm[13:0]});
		end
		ma  = s_tdata[192 +: 32];
		mb  = s_tdata[224 +: 32];
		mor = ma | mb;
		msh = (|mor[31:M_LIM]) ? 2'(msb32(mor) - 5'(M_LIM - 1)) : 2'd0;
		in_ma = 29'(ma >> msh);
		in_mb = 29'(mb >> msh);
	end

	logic signed [31:0] va_s1 [3], vb_s1 [3], n_s1 [3];
	logic [31:0]        nmag_s1 [3];
	logic signed [14:0] r_s1 [3];
	logic [28:0]        ma_s1, mb_s1;
	logic [1:0]         mode_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < 3; i++) begin
				va_s1[i]   <= in_va[i];
				vb_s1[i]   <= in_vb[i];
				n_s1[i]    <= in_n[i];
				nmag_s1[i] <= in_nmag[i];
				r_s1[i]    <= in_r[i];
			end
			ma_s1   <= in_ma;
			mb_s1   <= in_mb;
			mode_s1 <= s_tuser;
		end
	end

	// Stage 2: products.
	logic signed [31:0] va_s2 [3], vb_s2 [3], n_s2 [3];
	logic [31:0]        nmag_s2 [3];
	logic signed [14:0] r_s2 [3];
	logic [27:0]        rr_s2 [3];
	logic signed [46:0] vr_s2 [3];
	logic signed [61:0] dva_s2 [3], m2vb_s2 [3], m1va_s2 [3], dvb_s2 [3];
	logic [28:0]        div10_s2 [3];
	logic [29:0]        tot_s2;
	logic [1:0]         mode_s2;

	always_ff @(posedge clk) begin
		logic signed [29:0] diff, m1, m2;
		logic signed [31:0] vsel;
		logic [63:0]        pm;
		if (en_s2) begin
			m1   = $signed({1'b0, ma_s1});
			m2   = $signed({1'b0, mb_s1});
			diff = m1 - m2;
			for (int i = 0; i < 3; i++) begin
				vsel          = (mode_s1 == cvr_pkg::FIX_B) ? va_s1[i] : vb_s1[i];
				rr_s2[i]      <= 28'(r_s1[i] * r_s1[i]);
				vr_s2[i]      <= 47'(vsel * r_s1[i]);
				dva_s2[i]     <= 62'(diff * va_s1[i]);
				m2vb_s2[i]    <= 62'(m2 * vb_s1[i]);
				m1va_s2[i]    <= 62'(m1 * va_s1[i]);
				dvb_s2[i]     <= 62'(diff * vb_s1[i]);
				pm            = 64'(nmag_s1[i]) * 64'(RECIP10);
				div10_s2[i]   <= 29'(pm >> RECIP10_SH);
				va_s2[i]      <= va_s1[i];
				vb_s2[i]      <= vb_s1[i];
				n_s2[i]       <= n_s1[i];
				nmag_s2[i]    <= nmag_s1[i];
				r_s2[i]       <= r_s1[i];
			end
			tot_s2  <= 30'(ma_s1) + 30'(mb_s1);
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3: sums, elastic numerators and the position corrections.
	logic signed [31:0] va_s3 [3], vb_s3 [3];
	logic signed [14:0] r_s3 [3];
	logic [29:0]        d_s3, tot_s3;
	logic signed [48:0] q_s3;
	logic signed [63:0] numa_s3 [3], numb_s3 [3];
	cvr_pkg::tag_t      shift_s3;
	logic [1:0]         mode_s3;

	always_ff @(posedge clk) begin
		logic [32:0]        p;
		logic signed [33:0] ppos;
		logic signed [32:0] hsum;
		logic signed [31:0] h;
		if (en_s3) begin
			d_s3 <= 30'(rr_s2[0]) + 30'(rr_s2[1]) + 30'(rr_s2[2]);
			q_s3 <= 49'(vr_s2[0]) + 49'(vr_s2[1]) + 49'(vr_s2[2]);
			for (int i = 0; i < 3; i++) begin
				numa_s3[i] <= 64'(dva_s2[i]) + (64'(m2vb_s2[i]) <<< 1);
				numb_s3[i] <= (64'(m1va_s2[i]) <<< 1) - 64'(dvb_s2[i]);
				// n * 11 / 10 truncated is |n| + |n| / 10 with the sign put back.
				p    = {1'b0, nmag_s2[i]} + 33'(div10_s2[i]);
				ppos = n_s2[i][31] ? -$signed({1'b0, p}) : $signed({1'b0, p});
				hsum = 33'(n_s2[i]) + $signed({32'b0, n_s2[i][31]});
				h    = 32'(hsum >>> 1);
				unique case (mode_s2)
					cvr_pkg::FIX_B: begin
						shift_s3[i]   <= sat32(36'(ppos));
						shift_s3[3+i] <= '0;
					end
					cvr_pkg::FIX_A: begin
						shift_s3[i]   <= '0;
						shift_s3[3+i] <= sat32(36'(-ppos));
					end
					cvr_pkg::FIX_NONE: begin
						shift_s3[i]   <= h;
						shift_s3[3+i] <= 32'(-h);
					end
					default: begin
						shift_s3[i]   <= '0;
						shift_s3[3+i] <= '0;
					end
				endcase
				va_s3[i] <= va_s2[i];
				vb_s3[i] <= vb_s2[i];
				r_s3[i]  <= r_s2[i];
			end
			tot_s3  <= tot_s2;
			mode_s3 <= mode_s2;
		end
	end

	// Stage 4: reflection numerators 2 (v.n) n_i.
	logic signed [31:0] va_s4 [3], vb_s4 [3];
	logic signed [63:0] prod_s4 [3], numa_s4 [3], numb_s4 [3];
	logic [29:0]        d_s4, tot_s4;
	cvr_pkg::tag_t      shift_s4;
	logic [1:0]         mode_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int i = 0; i < 3; i++) begin
				prod_s4[i] <= 64'(q_s3 * r_s3[i]) <<< 1;
				numa_s4[i] <= numa_s3[i];
				numb_s4[i] <= numb_s3[i];
				va_s4[i]   <= va_s3[i];
				vb_s4[i]   <= vb_s3[i];
			end
			d_s4     <= d_s3;
			tot_s4   <= tot_s3;
			shift_s4 <= shift_s3;
			mode_s4  <= mode_s3;
		end
	end

	// Stage 5: pick each lane's base, dividend and divisor.
	cvr_pkg::lane_vec_t lane_nxt, lane_s5;
	cvr_pkg::tag_t      shift_s5;

	always_comb begin
		logic signed [63:0] nsig;
		logic [29:0]        den;
		logic signed [31:0] base;
		int                 ax;
		logic               is_a;
		for (int l = 0; l < cvr_pkg::LANES; l++) begin
			ax   = l % 3;
			is_a = l < 3;
			base = is_a ? va_s4[ax] : vb_s4[ax];
			nsig = '0;
			den  = 30'd1;
			unique case (mode_s4)
				cvr_pkg::FIX_B: begin
					if (is_a && d_s4 != '0) begin
						nsig = -prod_s4[ax];
						den  = d_s4;
					end
				end
				cvr_pkg::FIX_A: begin
					if (!is_a && d_s4 != '0) begin
						nsig = -prod_s4[ax];
						den  = d_s4;
					end
				end
				cvr_pkg::FIX_NONE: begin
					if (tot_s4 == '0) begin
						base = is_a ? vb_s4[ax] : va_s4[ax];
					end else begin
						base = '0;
						nsig = is_a ? numa_s4[ax] : numb_s4[ax];
						den  = tot_s4;
					end
				end
				default: begin
				end
			endcase
			lane_nxt[l].mag  = nsig[63] ? 64'(-nsig) : 64'(nsig);
			lane_nxt[l].neg  = nsig[63];
			lane_nxt[l].den  = den;
			lane_nxt[l].base = base;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			lane_s5  <= lane_nxt;
			shift_s5 <= shift_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	assign en_s5    = !v_s5 || div_in_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	cvr_pkg::lane_vec_t div_lane;
	cvr_pkg::quo_vec_t  div_quo;
	cvr_pkg::tag_t      div_tag;

	cvr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (div_in_ready),
		.in_lane   (lane_s5),
		.in_tag    (shift_s5),
		.out_valid (div_out_valid),
		.out_ready (en_o),
		.out_lane  (div_lane),
		.out_quo   (div_quo),
		.out_tag   (div_tag)
	);

	// Output register: base plus signed quotient, saturated.
	assign en_o = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en_o) begin
			m_tvalid <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [35:0] qs;
		logic signed [35:0] sum;
		if (en_o) begin
			for (int l = 0; l < cvr_pkg::LANES; l++) begin
				qs  = div_lane[l].neg ? -$signed({2'b0, div_quo[l]}) : $signed({2'b0, div_quo[l]});
				sum = 36'($signed(div_lane[l].base)) + qs;
				m_tdata[32*l +: 32]       <= sat32(sum);
				m_tdata[192 + 32*l +: 32] <= div_tag[l];
			end
		end
	end

	logic den_zero_s5;
	always_comb begin
		den_zero_s5 = 1'b0;
		for (int l = 0; l < cvr_pkg::LANES; l++) begin
			if (lane_s5[l].den == '0) den_zero_s5 = 1'b1;
		end
	end

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> !den_zero_s5)
		else $error("divider lane entered with a zero divisor");

	a_both_fixed_no_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && mode_s4 == cvr_pkg::FIX_BOTH) |-> (shift_s4 == '0))
		else $error("position correction set although both bodies are fixed");

	a_s5_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !div_in_ready) |=> (v_s5 && $stable(lane_s5) && $stable(shift_s5)))
		else $error("stalled item at the divider input changed");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(div_out_valid && !en_o) |=> div_out_valid)
		else $error("divider dropped an item while the output was stalled");

endmodule
